// File: design/imd_pkg.sv
// imd_pkg: shared types and constants for the disk image parser
// no dependencies; used by the track fsm, the top level and the testbench
`default_nettype none
package imd_pkg;

	localparam logic [7:0]  HDR_TERM      = 8'h1a;
	localparam logic [13:0] SECTOR_BASE   = 14'h0080;
	localparam int          CYL_MAP_BIT   = 7;
	localparam int          HEAD_MAP_BIT  = 6;
	localparam logic [7:0]  TYPE_ABSENT   = 8'd0;
	localparam logic [7:0]  TYPE_FILL     = 8'd2;
	localparam logic [2:0]  MAX_SIZE_CODE = 3'd6;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'd0,
		PH_MODE    = 4'd1,
		PH_CYL     = 4'd2,
		PH_HEAD    = 4'd3,
		PH_NSEC    = 4'd4,
		PH_SIZE    = 4'd5,
		PH_SECMAP  = 4'd6,
		PH_CYLMAP  = 4'd7,
		PH_HDMAP   = 4'd8,
		PH_SECTYPE = 4'd9,
		PH_FILL    = 4'd10,
		PH_DATA    = 4'd11,
		PH_DONE    = 4'd12
	} phase_t;

	typedef enum logic [3:0] {
		K_HEADER  = 4'd0,
		K_MODE    = 4'd1,
		K_CYL     = 4'd2,
		K_HEAD    = 4'd3,
		K_NSEC    = 4'd4,
		K_SIZE    = 4'd5,
		K_SECMAP  = 4'd6,
		K_CYLMAP  = 4'd7,
		K_HEADMAP = 4'd8,
		K_ABSENT  = 4'd9,
		K_DATA    = 4'd10,
		K_FILL    = 4'd11
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  value;
		logic [7:0]  sector_index;
		logic [12:0] byte_index;
		logic [13:0] fill_count;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

// File: design/imd_if.sv
// channel interfaces: input bytes, results and the configuration write
// depends on nothing but plain logic types
`default_nettype none
interface imd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface imd_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [7:0]  value;
	logic [7:0]  sector_index;
	logic [12:0] byte_index;
	logic [13:0] fill_count;
	logic        last;
	modport source (output valid, output kind, output value, output sector_index,
		output byte_index, output fill_count, output last, input ready);
	modport sink (input valid, input kind, input value, input sector_index,
		input byte_index, input fill_count, input last, output ready);
endinterface

interface imd_cfg_if;
	logic valid;
	logic ready;
	logic track_enable;
	modport source (output valid, output track_enable, input ready);
	modport sink (input valid, input track_enable, output ready);
endinterface
`default_nettype wire

// File: design/imd_track_fsm.sv
// imd_track_fsm: record phase, map flags, counters and one-byte decode
// depends on imd_pkg
`default_nettype none
module imd_track_fsm (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step,
	input  wire logic [7:0]    data_byte,
	input  wire logic          track_enable,
	output logic               res_valid,
	output imd_pkg::res_t      res
);
	import imd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  map_flags_q, map_flags_d;
	logic [7:0]  sector_total_q, sector_total_d;
	logic [2:0]  size_code_q, size_code_d;
	logic [7:0]  entry_cnt_q, entry_cnt_d;
	logic [13:0] byte_cnt_q, byte_cnt_d;

	logic [7:0]  entry_inc;
	logic        entry_end;
	logic [13:0] byte_inc;
	logic [13:0] sec_bytes;
	phase_t      sector_next;
	phase_t      map_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HEADER;
			map_flags_q    <= '0;
			sector_total_q <= '0;
			size_code_q    <= '0;
			entry_cnt_q    <= '0;
			byte_cnt_q     <= '0;
		end else if (step) begin
			phase_q        <= phase_d;
			map_flags_q    <= map_flags_d;
			sector_total_q <= sector_total_d;
			size_code_q    <= size_code_d;
			entry_cnt_q    <= entry_cnt_d;
			byte_cnt_q     <= byte_cnt_d;
		end
	end

	assign entry_inc   = entry_cnt_q + 8'd1;
	assign entry_end   = entry_inc >= sector_total_q;
	assign byte_inc    = byte_cnt_q + 14'd1;
	assign sec_bytes   = SECTOR_BASE << size_code_q;
	assign sector_next = entry_end ? PH_MODE : PH_SECTYPE;

	always_comb begin
		if (phase_q == PH_SECMAP && map_flags_q[1])
			map_next = PH_CYLMAP;
		else if (phase_q != PH_HDMAP && map_flags_q[0])
			map_next = PH_HDMAP;
		else
			map_next = PH_SECTYPE;
	end

	always_comb begin
		phase_d        = phase_q;
		map_flags_d    = map_flags_q;
		sector_total_d = sector_total_q;
		size_code_d    = size_code_q;
		entry_cnt_d    = entry_cnt_q;
		byte_cnt_d     = byte_cnt_q;
		res_valid      = 1'b1;
		res            = '{kind: K_HEADER, value: data_byte, sector_index: 8'd0,
			byte_index: 13'd0, fill_count: 14'd0, last: 1'b0};
		case (phase_q)
			PH_HEADER: begin
				if (data_byte == HDR_TERM) begin
					res_valid = 1'b0;
					phase_d   = track_enable ? PH_MODE : PH_DONE;
				end
			end
			PH_MODE: begin
				res.kind = K_MODE;
				phase_d  = PH_CYL;
			end
			PH_CYL: begin
				res.kind = K_CYL;
				phase_d  = PH_HEAD;
			end
			PH_HEAD: begin
				res.kind    = K_HEAD;
				map_flags_d = {data_byte[CYL_MAP_BIT], data_byte[HEAD_MAP_BIT]};
				phase_d     = PH_NSEC;
			end
			PH_NSEC: begin
				res.kind       = K_NSEC;
				sector_total_d = data_byte;
				phase_d        = PH_SIZE;
			end
			PH_SIZE: begin
				res.kind    = K_SIZE;
				size_code_d = (data_byte > {5'd0, MAX_SIZE_CODE}) ? MAX_SIZE_CODE
					: data_byte[2:0];
				entry_cnt_d = '0;
				byte_cnt_d  = '0;
				phase_d     = (sector_total_q == 8'd0) ? PH_MODE : PH_SECMAP;
			end
			PH_SECMAP, PH_CYLMAP, PH_HDMAP: begin
				case (phase_q)
					PH_SECMAP: res.kind = K_SECMAP;
					PH_CYLMAP: res.kind = K_CYLMAP;
					default:   res.kind = K_HEADMAP;
				endcase
				res.sector_index = entry_cnt_q;
				entry_cnt_d      = entry_inc;
				if (entry_end) begin
					res.last    = 1'b1;
					entry_cnt_d = '0;
					phase_d     = map_next;
				end
			end
			PH_SECTYPE: begin
				if (data_byte == TYPE_ABSENT) begin
					res.kind         = K_ABSENT;
					res.sector_index = entry_cnt_q;
					res.last         = 1'b1;
					entry_cnt_d      = entry_end ? 8'd0 : entry_inc;
					byte_cnt_d       = '0;
					phase_d          = sector_next;
				end else begin
					res_valid  = 1'b0;
					byte_cnt_d = '0;
					phase_d    = (data_byte == TYPE_FILL) ? PH_FILL : PH_DATA;
				end
			end
			PH_FILL: begin
				res.kind         = K_FILL;
				res.sector_index = entry_cnt_q;
				res.fill_count   = sec_bytes;
				res.last         = 1'b1;
				entry_cnt_d      = entry_end ? 8'd0 : entry_inc;
				byte_cnt_d       = '0;
				phase_d          = sector_next;
			end
			PH_DATA: begin
				res.kind         = K_DATA;
				res.sector_index = entry_cnt_q;
				res.byte_index   = byte_cnt_q[12:0];
				byte_cnt_d       = byte_inc;
				if (byte_inc >= sec_bytes) begin
					res.last    = 1'b1;
					entry_cnt_d = entry_end ? 8'd0 : entry_inc;
					byte_cnt_d  = '0;
					phase_d     = sector_next;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: design/imd_disk_image_parser_core.sv
// imd_disk_image_parser_core: top level, input register, track fsm, result register
// depends on imd_pkg, imd_if and imd_track_fsm
// each byte passes the input register and then the result register before its result is offered
// throughput one byte per cycle while results are taken; a byte that yields no result still takes one slot
// the input register frees while a result waits whenever the result register drains
// reset: async active low, fsm back to header phase, track_enable set to 1
`default_nettype none
module imd_disk_image_parser_core (
	input  wire logic clk,
	input  wire logic arst_n,
	imd_byte_if.sink  byte_in,
	imd_res_if.source res_out,
	imd_cfg_if.sink   cfg
);
	import imd_pkg::*;

	logic       track_enable_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       step;
	logic       res_valid;
	res_t       res;
	logic       out_valid_q;
	res_t       out_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			track_enable_q <= 1'b1;
		else if (cfg.valid)
			track_enable_q <= cfg.track_enable;
	end

	assign step         = valid_s1 && (!out_valid_q || res_out.ready);
	assign byte_in.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (byte_in.ready)
			valid_s1 <= byte_in.valid;
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready)
			data_s1 <= byte_in.data_byte;
	end

	imd_track_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte    (data_s1),
		.track_enable (track_enable_q),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step)
			out_valid_q <= res_valid;
		else if (res_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && res_valid)
			out_q <= res;
	end

	assign res_out.valid        = out_valid_q;
	assign res_out.kind         = out_q.kind;
	assign res_out.value        = out_q.value;
	assign res_out.sector_index = out_q.sector_index;
	assign res_out.byte_index   = out_q.byte_index;
	assign res_out.fill_count   = out_q.fill_count;
	assign res_out.last         = out_q.last;

endmodule
`default_nettype wire

// File: sim/testbench.sv
// testbench for imd_disk_image_parser_core: byte stream in, tagged parse results out
// depends on imd_pkg and the channel interfaces in imd_if; predicts every result itself
// directed tracks first, then random track streams under random stalls on both sides
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import imd_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int RESET_CYCLES   = 10;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 20;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_BYTES   = 150;
	localparam int TIMEOUT_CYCLES = 2000000;

	logic clk;
	logic arst_n;

	imd_byte_if byte_if ();
	imd_res_if  res_if ();
	imd_cfg_if  cfg_if ();

	imd_disk_image_parser_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	// parser state as predicted
	phase_t      ph;
	logic        trk_en;
	logic        cyl_map_on;
	logic        head_map_on;
	logic [7:0]  sec_total;
	logic [7:0]  size_code;
	logic [7:0]  entry_cnt;
	logic [13:0] byte_cnt;

	res_t pending_results[$];

	int   failures;
	int   bytes_sent;
	int   results_checked;
	int   tracks_sent;
	int   cfg_writes;
	int   rx_wait;
	logic no_idle;
	logic long_hold;
	event hold_ev;

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int sector_len(input logic [7:0] code);
		return 128 << ((code > MAX_SIZE_CODE) ? MAX_SIZE_CODE : code[2:0]);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic string fmt_result(input res_t r);
		return $sformatf("kind=%0d value=%02h sector=%0d byte=%0d fill=%0d last=%0b",
			r.kind, r.value, r.sector_index, r.byte_index, r.fill_count, r.last);
	endfunction

	task automatic report_failure(input string what);
		failures++;
		if (failures <= 10) begin
			$display("[%0t] %s", $time, what);
		end
	endtask

	task automatic advance_sector();
		entry_cnt = entry_cnt + 8'd1;
		byte_cnt = '0;
		if (entry_cnt >= sec_total) begin
			entry_cnt = '0;
			ph = PH_MODE;
		end else begin
			ph = PH_SECTYPE;
		end
	endtask

	// works out the result of one accepted stream byte
	task automatic parse_byte(input logic [7:0] b);
		res_t r;
		logic emit;
		r = '0;
		r.value = b;
		emit = 1'b1;
		case (ph)
			PH_HEADER: begin
				if (b == HDR_TERM) begin
					emit = 1'b0;
					ph = trk_en ? PH_MODE : PH_DONE;
				end else begin
					r.kind = K_HEADER;
				end
			end
			PH_MODE: begin
				r.kind = K_MODE;
				ph = PH_CYL;
			end
			PH_CYL: begin
				r.kind = K_CYL;
				ph = PH_HEAD;
			end
			PH_HEAD: begin
				r.kind = K_HEAD;
				cyl_map_on = b[CYL_MAP_BIT];
				head_map_on = b[HEAD_MAP_BIT];
				ph = PH_NSEC;
			end
			PH_NSEC: begin
				r.kind = K_NSEC;
				sec_total = b;
				ph = PH_SIZE;
			end
			PH_SIZE: begin
				r.kind = K_SIZE;
				size_code = (b > MAX_SIZE_CODE) ? 8'(MAX_SIZE_CODE) : b;
				entry_cnt = '0;
				byte_cnt = '0;
				ph = (sec_total == 8'd0) ? PH_MODE : PH_SECMAP;
			end
			PH_SECMAP, PH_CYLMAP, PH_HDMAP: begin
				r.kind = (ph == PH_SECMAP) ? K_SECMAP : (ph == PH_CYLMAP) ? K_CYLMAP : K_HEADMAP;
				r.sector_index = entry_cnt;
				entry_cnt = entry_cnt + 8'd1;
				if (entry_cnt >= sec_total) begin
					r.last = 1'b1;
					entry_cnt = '0;
					if (ph == PH_SECMAP && cyl_map_on) ph = PH_CYLMAP;
					else if (ph != PH_HDMAP && head_map_on) ph = PH_HDMAP;
					else ph = PH_SECTYPE;
				end
			end
			PH_SECTYPE: begin
				if (b == TYPE_ABSENT) begin
					r.kind = K_ABSENT;
					r.sector_index = entry_cnt;
					r.last = 1'b1;
					advance_sector();
				end else begin
					emit = 1'b0;
					byte_cnt = '0;
					ph = (b == TYPE_FILL) ? PH_FILL : PH_DATA;
				end
			end
			PH_FILL: begin
				r.kind = K_FILL;
				r.sector_index = entry_cnt;
				r.fill_count = 14'(sector_len(size_code));
				r.last = 1'b1;
				advance_sector();
			end
			PH_DATA: begin
				r.kind = K_DATA;
				r.sector_index = entry_cnt;
				r.byte_index = byte_cnt[12:0];
				byte_cnt = byte_cnt + 14'd1;
				if (byte_cnt >= sector_len(size_code)) begin
					r.last = 1'b1;
					advance_sector();
				end
			end
			default: emit = 1'b0;
		endcase
		if (emit) pending_results.push_back(r);
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		byte_if.valid <= 1'b1;
		byte_if.data_byte <= b;
		do @(posedge clk); while (!byte_if.ready);
		parse_byte(b);
		bytes_sent++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			byte_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		byte_if.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic cfg_write(input logic en);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.track_enable <= en;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		trk_en = en;
		cfg_writes++;
	endtask

	task automatic send_fields(input logic [7:0] mode, input logic [7:0] cyl,
		input logic [7:0] head, input logic [7:0] nsec, input logic [7:0] size);
		send_byte(mode);
		send_byte(cyl);
		send_byte(head);
		send_byte(nsec);
		send_byte(size);
		tracks_sent++;
	endtask

	task automatic send_maps(input logic [7:0] nsec, input logic [7:0] head);
		repeat (nsec) send_byte(8'($urandom));
		if (head[CYL_MAP_BIT]) repeat (nsec) send_byte(8'($urandom));
		if (head[HEAD_MAP_BIT]) repeat (nsec) send_byte(8'($urandom));
	endtask

	task automatic send_sector(input logic [7:0] typ, input logic [7:0] size);
		send_byte(typ);
		if (typ == TYPE_FILL) send_byte(8'($urandom));
		else if (typ != TYPE_ABSENT) repeat (sector_len(size)) send_byte(8'($urandom));
	endtask

	function automatic logic [7:0] raw_type();
		logic [7:0] t;
		do t = 8'($urandom); while (t == TYPE_ABSENT || t == TYPE_FILL);
		return t;
	endfunction

	task automatic send_random_track();
		logic [7:0] head;
		logic [7:0] nsec;
		logic [7:0] size;
		logic [7:0] typ;
		logic raw_ok;
		int r;
		head = 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 10) nsec = 8'd0;
		else if (r < 75) nsec = 8'($urandom_range(1, 4));
		else if (r < 95) nsec = 8'($urandom_range(5, 16));
		else nsec = 8'($urandom_range(17, 60));
		r = $urandom_range(0, 99);
		if (r < 80) size = 8'd0;
		else if (r < 88) size = 8'd1;
		else size = 8'($urandom_range(2, 255));
		raw_ok = (sector_len(size) <= 256) && (nsec <= 4);
		send_fields(8'($urandom), 8'($urandom), head, nsec, size);
		send_maps(nsec, head);
		repeat (nsec) begin
			r = $urandom_range(0, 99);
			if (r < 35) typ = TYPE_ABSENT;
			else if (r < 65 || !raw_ok) typ = TYPE_FILL;
			else typ = raw_type();
			send_sector(typ, size);
		end
	endtask

	// track fields with garbage after them, run until the next track boundary
	task automatic send_noise_track();
		send_fields(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 3)), 8'd0);
		while (ph != PH_MODE) send_byte(8'($urandom));
	endtask

	task automatic test_header();
		cfg_write(1'b0);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h1b);
		send_byte(8'h19);
		send_byte(8'h55);
		send_byte(8'haa);
		cfg_write(1'b1);
		send_byte(8'h80);
		send_byte(HDR_TERM);
	endtask

	task automatic test_track_fields();
		send_fields(8'hff, 8'h00, 8'h3f, 8'd0, 8'hff);
		send_fields(8'h00, 8'hff, 8'hc5, 8'd3, 8'd0);
		send_maps(8'd3, 8'hc5);
		send_sector(TYPE_ABSENT, 8'd0);
		send_sector(TYPE_FILL, 8'd0);
		send_sector(8'd1, 8'd0);
		send_fields(8'($urandom), 8'($urandom), 8'h80, 8'd1, 8'd1);
		send_maps(8'd1, 8'h80);
		send_sector(8'hff, 8'd1);
		send_fields(8'($urandom), 8'($urandom), 8'h40, 8'd2, 8'd7);
		send_maps(8'd2, 8'h40);
		send_sector(TYPE_FILL, 8'd7);
		send_sector(TYPE_ABSENT, 8'd7);
	endtask

	task automatic test_sector_sizes();
		for (int s = 2; s <= 6; s++) begin
			send_fields(8'($urandom), 8'($urandom), 8'h00, 8'd1, 8'(s));
			send_maps(8'd1, 8'h00);
			send_sector(TYPE_FILL, 8'(s));
		end
		no_idle = 1'b1;
		send_fields(8'($urandom), 8'($urandom), 8'h00, 8'd1, 8'd0);
		send_maps(8'd1, 8'h00);
		send_sector(8'd3, 8'd0);
		no_idle = 1'b0;
	endtask

	task automatic test_full_track();
		send_fields(8'($urandom), 8'($urandom), 8'h00, 8'd255, 8'd0);
		send_maps(8'd255, 8'h00);
		repeat (255) send_sector($urandom_range(0, 1) ? TYPE_FILL : TYPE_ABSENT, 8'd0);
	endtask

	task automatic test_cfg_midstream();
		cfg_write(1'b0);
		send_random_track();
		cfg_write(1'b1);
		send_random_track();
		cfg_write(1'b0);
		cfg_write(1'b1);
		send_random_track();
	endtask

	task automatic test_backpressure();
		-> hold_ev;
		no_idle = 1'b1;
		repeat (4) begin
			send_fields(8'($urandom), 8'($urandom), 8'h00, 8'd2, 8'd0);
			send_maps(8'd2, 8'h00);
			send_sector(TYPE_ABSENT, 8'd0);
			send_sector(TYPE_FILL, 8'd0);
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	task automatic test_random_stream();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_BYTES) begin
			no_idle = ($urandom_range(0, 99) < 15);
			if ($urandom_range(0, 99) < 5) cfg_write(1'($urandom_range(0, 1)));
			if ($urandom_range(0, 99) < 15) send_noise_track();
			else send_random_track();
		end
		no_idle = 1'b0;
	endtask

	always begin : hold_off
		@(hold_ev);
		long_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold = 1'b0;
	end

	always @(posedge clk) begin : result_side
		res_t got;
		res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.kind = kind_t'(res_if.kind);
			got.value = res_if.value;
			got.sector_index = res_if.sector_index;
			got.byte_index = res_if.byte_index;
			got.fill_count = res_if.fill_count;
			got.last = res_if.last;
			if (pending_results.size() == 0) begin
				report_failure({"unexpected result: ", fmt_result(got)});
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					report_failure($sformatf("result %0d: expected %s, got %s",
						results_checked, fmt_result(want), fmt_result(got)));
				end
			end
			results_checked++;
		end
		if (long_hold) begin
			res_if.ready <= 1'b0;
		end else if (rx_wait > 0) begin
			res_if.ready <= 1'b0;
			rx_wait--;
		end else if (no_idle || $urandom_range(0, 99) < 60) begin
			res_if.ready <= 1'b1;
		end else begin
			res_if.ready <= 1'b0;
			rx_wait = pick_gap();
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int waited;
		clk = 1'b0;
		arst_n = 1'b0;
		byte_if.valid = 1'b0;
		byte_if.data_byte = '0;
		res_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.track_enable = 1'b1;
		ph = PH_HEADER;
		trk_en = 1'b1;
		cyl_map_on = 1'b0;
		head_map_on = 1'b0;
		sec_total = '0;
		size_code = '0;
		entry_cnt = '0;
		byte_cnt = '0;
		failures = 0;
		bytes_sent = 0;
		results_checked = 0;
		tracks_sent = 0;
		cfg_writes = 0;
		rx_wait = 0;
		no_idle = 1'b0;
		long_hold = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header();
		test_track_fields();
		test_sector_sizes();
		test_full_track();
		test_cfg_midstream();
		test_backpressure();
		test_random_stream();

		byte_if.valid <= 1'b0;
		waited = 0;
		do begin
			@(posedge clk);
			waited++;
		end while (pending_results.size() != 0 && waited < DRAIN_LIMIT);
		if (pending_results.size() != 0) begin
			report_failure($sformatf("%0d results never arrived, first: %s",
				pending_results.size(), fmt_result(pending_results[0])));
		end
		repeat (END_CYCLES) @(posedge clk);

		$display("covered %0d stream bytes in %0d tracks with %0d register writes",
			bytes_sent, tracks_sent, cfg_writes);
		$display("checked %0d results, %0d failures", results_checked, failures);
		if (failures == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
